// ----- rtl/tkrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkrt_pkg
// Types, constants and helpers shared by the top-k ranked table.
// ----------------------------------------------------------------------------
package tkrt_pkg;

	localparam int ENTRIES = 10;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [7:0] LETTER_A = 8'h41;
	localparam logic [7:0] LETTER_Z = 8'h5A;
	localparam logic [7:0] LOWER_A  = 8'h61;
	localparam logic [7:0] LOWER_Z  = 8'h7A;
	localparam logic [23:0] TAG_AAA = {LETTER_A, LETTER_A, LETTER_A};

	localparam logic MODE_SUBMIT = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [7:0]         letter_first;
		logic [7:0]         letter_second;
		logic [7:0]         letter_third;
		logic signed [31:0] new_score;
		logic [3:0]         read_rank;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic        read_ok;
		logic [7:0]  tag_first;
		logic [7:0]  tag_second;
		logic [7:0]  tag_third;
		logic [30:0] entry_score;
	} resp_t;

	typedef struct packed {
		logic [23:0] tag;
		logic [30:0] score;
	} entry_t;

	localparam entry_t RESET_ENTRY = '{tag: TAG_AAA, score: 31'd0};

	function automatic logic [7:0] norm_letter(input logic [7:0] raw);
		logic [7:0] c;
		c = raw;
		if (c >= LOWER_A && c <= LOWER_Z) begin
			c = c - LOWER_A + LETTER_A;
		end
		if (c < LETTER_A || c > LETTER_Z) begin
			c = LETTER_A;
		end
		return c;
	endfunction

endpackage

// ----- rtl/top_k_ranked_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_ranked_table_unit
// Score table of ENTRIES tagged entries kept sorted from high to low.
// ----------------------------------------------------------------------------
// Usage: a request on req_* either submits a tag and score (mode 0) or reads
// the entry at a rank (mode 1). Every request gives exactly one response on
// resp_*, in order. A request is taken only while the unit is idle.
// Flow: a read fetches its entry from the table memory (S_RD), then goes to
// S_FIN; an out-of-range read or a zero or negative submit goes straight to
// S_FIN, and a submit that does not beat the lowest entry ends after S_LOW.
// An accepted submit walks the table upward from the lowest entry, one memory
// read and one write per cycle, moving lower entries down (S_WALK, S_PLACE).
// A new request is taken only once the last one has moved its response to
// the output register, so the unit handles one request at a time.
// Reset: the table reads as tag AAA with score zero; per-entry valid flops
// are cleared at once, so no clearing pass is needed.
// Stall: the response sits in an output register; a new request is taken
// while it waits, and the unit holds its next response until resp_ready.
// ----------------------------------------------------------------------------
module top_k_ranked_table_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tkrt_pkg::req_t req_data,
	output logic           resp_valid,
	input  logic           resp_ready,
	output tkrt_pkg::resp_t resp_data
);
	import tkrt_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOW   = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_PLACE = 3'd3;
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	logic [2:0]       state_q, state_d;
	entry_t           cur_q, cur_d;
	logic [IDX_W-1:0] pos_q, pos_d;
	resp_t            res_q, res_d;

	entry_t           mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	entry_t           rd_q;
	logic             rd_vld_q;
	entry_t           rd_eff;

	logic             rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	entry_t           wr_data;

	logic             accept;
	logic             positive;
	logic [31:0]      rank_ext;
	logic             rank_ok;
	logic             out_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign positive  = !req_data.new_score[31] && (req_data.new_score != 32'sd0);
	assign rank_ext  = 32'(req_data.read_rank);
	assign rank_ok   = (rank_ext < 32'(ENTRIES));
	assign out_free  = !resp_valid || resp_ready;
	assign rd_eff    = rd_vld_q ? rd_q : RESET_ENTRY;

	always_comb begin
		state_d = state_q;
		cur_d   = cur_q;
		pos_d   = pos_q;
		res_d   = res_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_d   = '0;
					cur_d.tag = {norm_letter(req_data.letter_first),
						norm_letter(req_data.letter_second),
						norm_letter(req_data.letter_third)};
					cur_d.score = req_data.new_score[30:0];
					if (req_data.mode == MODE_SUBMIT) begin
						if (positive) begin
							rd_en   = 1'b1;
							rd_addr = LAST_IDX;
							state_d = S_LOW;
						end else begin
							state_d = S_FIN;
						end
					end else if (rank_ok) begin
						rd_en   = 1'b1;
						rd_addr = rank_ext[IDX_W-1:0];
						state_d = S_RD;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_LOW: begin
				if (cur_q.score > rd_eff.score) begin
					res_d.accepted = 1'b1;
					rd_en   = 1'b1;
					rd_addr = LAST_IDX - IDX_W'(1);
					pos_d   = LAST_IDX;
					state_d = S_WALK;
				end else begin
					state_d = S_FIN;
				end
			end
			S_WALK: begin
				// rd_eff holds the entry just above pos_q
				wr_en   = 1'b1;
				wr_addr = pos_q;
				if (rd_eff.score < cur_q.score) begin
					wr_data = rd_eff;
					pos_d   = pos_q - IDX_W'(1);
					if (pos_q == IDX_W'(1)) begin
						state_d = S_PLACE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = pos_q - IDX_W'(2);
					end
				end else begin
					wr_data = cur_q;
					state_d = S_FIN;
				end
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = cur_q;
				state_d = S_FIN;
			end
			S_RD: begin
				res_d.read_ok     = 1'b1;
				res_d.tag_first   = rd_eff.tag[23:16];
				res_d.tag_second  = rd_eff.tag[15:8];
				res_d.tag_third   = rd_eff.tag[7:0];
				res_d.entry_score = rd_eff.score;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// table memory, one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q     <= mem[rd_addr];
			rd_vld_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			resp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (state_q == S_FIN && out_free) begin
				resp_valid <= 1'b1;
			end else if (resp_ready) begin
				resp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		pos_q <= pos_d;
		res_q <= res_d;
		if (state_q == S_FIN && out_free) begin
			resp_data <= res_q;
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the top-k ranked table unit. A local score table
// mirrors the unit and predicts every response. The bench covers reset
// contents, letter folding, rejected and equal scores, out-of-range ranks,
// random traffic with idle cycles on both sides, and a long response stall.
// ----------------------------------------------------------------------------
module tb_top;
	import tkrt_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam logic [31:0] SCORE_MAX = 32'h7FFF_FFFF;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   req_valid = 1'b0;
	logic   req_ready;
	req_t   req_data = '0;
	logic   resp_valid;
	logic   resp_ready = 1'b0;
	resp_t  resp_data;

	// local copy of the ranked table
	logic [23:0] model_tags [ENTRIES];
	logic [30:0] model_scores [ENTRIES];

	resp_t answers_due [$];
	int    error_count = 0;
	int    cycle_count = 0;
	int    hold_cycles = 0;
	bit    steady = 1'b0;
	int    n_inserted = 0;
	int    n_rejected = 0;
	int    n_reads_ok = 0;
	int    n_reads_out = 0;

	top_k_ranked_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.resp_valid(resp_valid),
		.resp_ready(resp_ready),
		.resp_data (resp_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [7:0] fold_letter(input logic [7:0] b);
		if (b >= LOWER_A && b <= LOWER_Z)
			return b - (LOWER_A - LETTER_A);
		if (b >= LETTER_A && b <= LETTER_Z)
			return b;
		return LETTER_A;
	endfunction

	// updates the local table and gives the response the unit must return
	function automatic resp_t apply_to_ranking(input req_t r);
		resp_t       a;
		int          pos;
		logic [30:0] s;
		a = '0;
		if (r.mode == MODE_SUBMIT) begin
			s = r.new_score[30:0];
			if (r.new_score > 0 && s > model_scores[ENTRIES-1]) begin
				pos = ENTRIES - 1;
				while (pos > 0 && model_scores[pos-1] < s) begin
					model_scores[pos] = model_scores[pos-1];
					model_tags[pos] = model_tags[pos-1];
					pos--;
				end
				model_scores[pos] = s;
				model_tags[pos] = {fold_letter(r.letter_first), fold_letter(r.letter_second),
					fold_letter(r.letter_third)};
				a.accepted = 1'b1;
				n_inserted++;
			end else begin
				n_rejected++;
			end
		end else if (r.read_rank < ENTRIES) begin
			a.read_ok = 1'b1;
			a.tag_first = model_tags[r.read_rank][23:16];
			a.tag_second = model_tags[r.read_rank][15:8];
			a.tag_third = model_tags[r.read_rank][7:0];
			a.entry_score = model_scores[r.read_rank];
			n_reads_ok++;
		end else begin
			n_reads_out++;
		end
		return a;
	endfunction

	function automatic req_t make_submit(input logic [7:0] l1, input logic [7:0] l2,
		input logic [7:0] l3, input logic [31:0] score);
		req_t r;
		r = '0;
		r.mode = MODE_SUBMIT;
		r.letter_first = l1;
		r.letter_second = l2;
		r.letter_third = l3;
		r.new_score = score;
		return r;
	endfunction

	function automatic req_t make_read(input logic [3:0] rank);
		req_t r;
		r = '0;
		r.mode = MODE_READ;
		r.read_rank = rank;
		return r;
	endfunction

	function automatic logic [7:0] pick_letter();
		case ($urandom_range(3))
			0: return 8'($urandom_range(LETTER_A, LETTER_Z));
			1: return 8'($urandom_range(LOWER_A, LOWER_Z));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// scores mostly land around the current lowest entry so inserts, ties
	// and rejects all keep happening as the table climbs
	function automatic req_t random_request();
		req_t   r;
		longint lowest;
		longint cand;
		int     sel;
		r.mode = ($urandom_range(1) == 1) ? MODE_READ : MODE_SUBMIT;
		r.letter_first = pick_letter();
		r.letter_second = pick_letter();
		r.letter_third = pick_letter();
		r.read_rank = 4'($urandom_range(15));
		lowest = longint'(model_scores[ENTRIES-1]);
		sel = $urandom_range(99);
		if (sel < 55) begin
			cand = lowest + longint'($urandom_range(40)) - 4;
			if (cand > longint'(SCORE_MAX))
				cand = longint'(SCORE_MAX);
			r.new_score = 32'(cand);
		end else if (sel < 70) begin
			r.new_score = 32'($urandom_range(1, 60));
		end else if (sel < 88) begin
			r.new_score = $urandom;
		end else begin
			case ($urandom_range(2))
				0: r.new_score = 32'sd0;
				1: r.new_score = -32'sd1;
				default: r.new_score = 32'h8000_0000 | $urandom;
			endcase
		end
		return r;
	endfunction

	task automatic send_request(input req_t r);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 35) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		answers_due.push_back(apply_to_ranking(r));
	endtask

	task automatic drain_responses();
		@(negedge clk);
		req_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			resp_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			resp_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (steady) begin
			resp_ready <= 1'b1;
		end else begin
			resp_ready <= ($urandom_range(99) >= 35);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		resp_t want;
		if (arst_n && resp_valid && resp_ready) begin
			if (answers_due.size() == 0) begin
				$error("response with no request outstanding");
				error_count++;
			end else begin
				want = answers_due.pop_front();
				check_field("accepted", 32'(want.accepted), 32'(resp_data.accepted));
				check_field("read_ok", 32'(want.read_ok), 32'(resp_data.read_ok));
				check_field("tag_first", 32'(want.tag_first), 32'(resp_data.tag_first));
				check_field("tag_second", 32'(want.tag_second), 32'(resp_data.tag_second));
				check_field("tag_third", 32'(want.tag_third), 32'(resp_data.tag_third));
				check_field("entry_score", 32'(want.entry_score),
					32'(resp_data.entry_score));
			end
		end
	end

	task automatic test_reset_contents();
		send_request(make_read(4'd0));
		send_request(make_read(4'(ENTRIES - 1)));
		send_request(make_read(4'(ENTRIES)));
		send_request(make_read(4'd15));
		drain_responses();
	endtask

	// fill with ties and odd bytes, then hit each reject rule
	task automatic test_directed_submits();
		send_request(make_submit(8'h00, 8'hFF, 8'h61, 32'd7));
		send_request(make_submit(8'h7A, 8'h41, 8'h5A, 32'd7));
		send_request(make_submit(8'h40, 8'h5B, 8'h60, 32'd3));
		send_request(make_submit(8'h7B, 8'h80, 8'h6D, SCORE_MAX));
		send_request(make_submit(8'h51, 8'h20, 8'h7F, 32'd3));
		send_request(make_submit(8'h62, 8'h79, 8'h4D, 32'd7));
		send_request(make_submit(8'h01, 8'hC1, 8'hE1, 32'd3));
		send_request(make_submit(8'h5A, 8'h5A, 8'h5A, 32'd9));
		send_request(make_submit(8'h41, 8'h7A, 8'h30, 32'd3));
		send_request(make_submit(8'h44, 8'h45, 8'h46, 32'd3));
		// equal to lowest, zero, negative, most negative
		send_request(make_submit(8'h47, 8'h48, 8'h49, 32'd3));
		send_request(make_submit(8'h47, 8'h48, 8'h49, 32'd0));
		send_request(make_submit(8'h47, 8'h48, 8'h49, 32'hFFFF_FFFF));
		send_request(make_submit(8'h47, 8'h48, 8'h49, 32'h8000_0000));
		send_request(make_submit(8'h4A, 8'h4B, 8'h4C, 32'd4));
		send_request(make_read(4'd0));
		send_request(make_read(4'd5));
		send_request(make_read(4'(ENTRIES - 1)));
		send_request(make_read(4'(ENTRIES)));
		send_request(make_read(4'd15));
		drain_responses();
	endtask

	task automatic test_random_traffic(input int count, input bit no_gaps);
		steady = no_gaps;
		repeat (count)
			send_request(random_request());
		drain_responses();
		steady = 1'b0;
	endtask

	// receiver stalls while requests keep coming, so the unit backs up
	task automatic test_response_stall();
		@(posedge clk);
		hold_cycles = 300;
		steady = 1'b1;
		repeat (12)
			send_request(random_request());
		drain_responses();
		steady = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			model_tags[i] = TAG_AAA;
			model_scores[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_contents();
		test_directed_submits();
		test_random_traffic(1300, 1'b0);
		test_random_traffic(200, 1'b1);
		test_response_stall();
		test_random_traffic(120, 1'b0);

		repeat (ENTRIES + 8) @(posedge clk);
		if (answers_due.size() != 0) begin
			$error("%0d responses never arrived", answers_due.size());
			error_count++;
		end
		$display("covered %0d inserts, %0d rejected submits, %0d in-range reads, %0d %s",
			n_inserted, n_rejected, n_reads_ok, n_reads_out, "out-of-range reads");
		$display("with idle gaps on both sides, a no-gap stretch and a long response stall");
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tkrt_pkg.sv
rtl/top_k_ranked_table_unit.sv
tb/sv/tb_top.sv
